// ----- rtl/csb_pkg.sv -----
// shared types, constants and the divide-by-five helper for the cross stencil blur
package csb_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 16;
    localparam int COLCFG_W    = 11;
    localparam int MAX_COLS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int CEFF_W      = (COL_W + 1 > COLCFG_W) ? COL_W + 1 : COLCFG_W;
    localparam int CFG_DATA_W  = (ROW_W > COLCFG_W) ? ROW_W : COLCFG_W;
    localparam int CFG_INDEX_W = 2;
    localparam int SUM_W       = 11;
    localparam int DIV5_MUL    = 3277;
    localparam int DIV5_MUL_W  = 12;
    localparam int DIV5_SHIFT  = 14;
    localparam int PROD_W      = SUM_W + DIV5_MUL_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = CFG_INDEX_W'(1);

    typedef enum logic [0:0] {
        BACK_FIRST,
        BACK_SECOND
    } back_state_t;

    // one request's worth of results, as handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] first_val;   // sum plus two when blurring, else the pixel
        logic             first_blur;
        logic             first_fl;
        logic             has_second;
        logic [PIX_W-1:0] second_pix;
        logic             second_fl;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // floor(x / 5), kept to PIX_W bits, for x below 2**SUM_W via multiply by reciprocal
    function automatic logic [PIX_W-1:0] div5(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(DIV5_MUL);
        return prod[DIV5_SHIFT +: PIX_W];
    endfunction

endpackage

// ----- rtl/csb_ram.sv -----
// generic single write, single registered read memory (read returns old data)
module csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/csb_front.sv -----
// front part: frame position, line stores, stencil sum and result classification
module csb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [csb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [csb_pkg::PIX_W-1:0]        in_pixel,
    output logic                             q_push,
    output csb_pkg::entry_t                  q_entry,
    input  csb_pkg::q_status_t               q_status
);

    localparam int PW = csb_pkg::PIX_W;
    localparam int CW = csb_pkg::COL_W;
    localparam int RW = csb_pkg::ROW_W;
    localparam int EW = csb_pkg::CEFF_W;
    localparam int SW = csb_pkg::SUM_W;

    logic [RW-1:0]                 row_count_reg, row_count_next;
    logic [csb_pkg::COLCFG_W-1:0]  col_count_reg, col_count_next;
    logic [RW-1:0]                 row_idx_reg, row_idx_next;
    logic [CW-1:0]                 col_idx_reg, col_idx_next;

    logic          s1_valid_reg, s1_valid_next;
    logic [CW-1:0] s1_col_reg;
    logic [PW-1:0] s1_pix_reg;
    logic          s1_push_reg, s1_blur_reg, s1_single_reg, s1_last_row_reg, s1_col_end_reg;
    logic [PW-1:0] left_reg;

    logic [RW-1:0] rows_eff;
    logic [EW-1:0] cols_eff;
    logic          single, last_row, col_end, interior, accept, s1_leave;
    logic [PW-1:0] center, top, right;
    logic [SW-1:0] sum2;

    always_comb
    begin
        rows_eff = (row_count_reg == '0) ? RW'(1) : row_count_reg;
        if (col_count_reg == '0)
        begin
            cols_eff = EW'(1);
        end
        else if (EW'(col_count_reg) > EW'(csb_pkg::MAX_COLS))
        begin
            cols_eff = EW'(csb_pkg::MAX_COLS);
        end
        else
        begin
            cols_eff = EW'(col_count_reg);
        end
    end

    assign single   = (rows_eff == RW'(1));
    assign last_row = ({1'b0, row_idx_reg} + (RW+1)'(1)) == {1'b0, rows_eff};
    assign col_end  = (EW'(col_idx_reg) + EW'(1)) == cols_eff;
    assign interior = (row_idx_reg >= RW'(2)) && (col_idx_reg != '0)
                    && ((EW'(col_idx_reg) + EW'(1)) < cols_eff);

    assign s1_leave = !s1_push_reg || !q_status.full;
    assign in_ready = !s1_valid_reg || s1_leave;
    assign accept   = in_valid && in_ready;

    // line stores: two copies of the newer row so center and right read together
    csb_ram #(.WIDTH(PW), .DEPTH(csb_pkg::MAX_COLS)) u_newer_c (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_idx_reg),
        .wr_data (in_pixel),
        .rd_en   (accept),
        .rd_addr (col_idx_reg),
        .rd_data (center)
    );

    csb_ram #(.WIDTH(PW), .DEPTH(csb_pkg::MAX_COLS)) u_newer_r (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_idx_reg),
        .wr_data (in_pixel),
        .rd_en   (accept),
        .rd_addr (col_idx_reg + CW'(1)),
        .rd_data (right)
    );

    // older row takes the displaced newer pixel in the cycle after the request
    csb_ram #(.WIDTH(PW), .DEPTH(csb_pkg::MAX_COLS)) u_older (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (center),
        .rd_en   (accept),
        .rd_addr (col_idx_reg),
        .rd_data (top)
    );

    assign sum2 = SW'(center) + SW'(top) + SW'(s1_pix_reg) + SW'(left_reg) + SW'(right)
                + SW'(2);

    always_comb
    begin
        q_push = s1_valid_reg && s1_push_reg && !q_status.full;
        if (s1_blur_reg)
        begin
            q_entry.first_val = sum2;
        end
        else if (s1_single_reg)
        begin
            q_entry.first_val = SW'(s1_pix_reg);
        end
        else
        begin
            q_entry.first_val = SW'(center);
        end
        q_entry.first_blur = s1_blur_reg;
        q_entry.first_fl   = s1_single_reg && s1_col_end_reg;
        q_entry.has_second = !s1_single_reg && s1_last_row_reg;
        q_entry.second_pix = s1_pix_reg;
        q_entry.second_fl  = s1_col_end_reg;
    end

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        row_idx_next   = row_idx_reg;
        col_idx_next   = col_idx_reg;
        if (cfg_wr_en && (cfg_index == csb_pkg::REG_ROW_COUNT))
        begin
            row_count_next = cfg_data[RW-1:0];
            row_idx_next   = '0;
            col_idx_next   = '0;
        end
        else if (cfg_wr_en && (cfg_index == csb_pkg::REG_COL_COUNT))
        begin
            col_count_next = cfg_data[csb_pkg::COLCFG_W-1:0];
            row_idx_next   = '0;
            col_idx_next   = '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_idx_next = '0;
                row_idx_next = last_row ? '0 : row_idx_reg + RW'(1);
            end
            else
            begin
                col_idx_next = col_idx_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_leave)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= RW'(1);
            col_count_reg <= csb_pkg::COLCFG_W'(1);
            row_idx_reg   <= '0;
            col_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            row_idx_reg   <= row_idx_next;
            col_idx_reg   <= col_idx_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= col_idx_reg;
            s1_pix_reg      <= in_pixel;
            s1_push_reg     <= single || (row_idx_reg != '0);
            s1_blur_reg     <= interior;
            s1_single_reg   <= single;
            s1_last_row_reg <= last_row;
            s1_col_end_reg  <= col_end;
        end
        // left neighbor is the center of the previous pixel in the row
        if (s1_valid_reg && s1_leave)
        begin
            left_reg <= center;
        end
    end

endmodule

// ----- rtl/csb_queue.sv -----
// short request queue between the front and back parts
module csb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  csb_pkg::entry_t    push_entry,
    input  logic               pop,
    output csb_pkg::entry_t    head,
    output csb_pkg::q_status_t status
);

    localparam int PTW = csb_pkg::QPTR_W;
    localparam int CTW = csb_pkg::QCNT_W;

    csb_pkg::entry_t slot_reg [csb_pkg::QUEUE_DEPTH];
    logic [PTW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CTW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTW'(csb_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTW'(csb_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CTW'(csb_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CTW'(csb_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CTW'(csb_pkg::QUEUE_DEPTH))
        |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CTW'(1)))
        else $error("queue push lost");
`endif

endmodule

// ----- rtl/csb_back.sv -----
// back part: turns queued requests into one or two results in the output register
module csb_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  csb_pkg::entry_t           head,
    input  csb_pkg::q_status_t        q_status,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [csb_pkg::PIX_W-1:0] out_pixel,
    output logic                      out_run_last,
    output logic                      out_frame_last
);

    localparam int PW = csb_pkg::PIX_W;

    csb_pkg::back_state_t state_reg, state_next;
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] pixel_reg, pixel_next;
    logic          run_last_reg, run_last_next;
    logic          frame_last_reg, frame_last_next;
    logic          load, take;

    assign load = !out_valid_reg || out_ready;
    assign take = load && !q_status.empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csb_pkg::BACK_FIRST:
            begin
                if (take && head.has_second)
                begin
                    state_next = csb_pkg::BACK_SECOND;
                end
            end
            csb_pkg::BACK_SECOND:
            begin
                if (take)
                begin
                    state_next = csb_pkg::BACK_FIRST;
                end
            end
            default:
            begin
                state_next = csb_pkg::BACK_FIRST;
            end
        endcase
    end

    always_comb
    begin
        pop             = 1'b0;
        out_valid_next  = load ? !q_status.empty : out_valid_reg;
        pixel_next      = pixel_reg;
        run_last_next   = run_last_reg;
        frame_last_next = frame_last_reg;
        case (state_reg)
            csb_pkg::BACK_FIRST:
            begin
                if (take)
                begin
                    pixel_next      = head.first_blur ? csb_pkg::div5(head.first_val)
                                    : head.first_val[PW-1:0];
                    run_last_next   = !head.has_second;
                    frame_last_next = head.first_fl;
                    pop             = !head.has_second;
                end
            end
            csb_pkg::BACK_SECOND:
            begin
                if (take)
                begin
                    pixel_next      = head.second_pix;
                    run_last_next   = 1'b1;
                    frame_last_next = head.second_fl;
                    pop             = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csb_pkg::BACK_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg      <= pixel_next;
        run_last_reg   <= run_last_next;
        frame_last_reg <= frame_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_pixel      = pixel_reg;
    assign out_run_last   = run_last_reg;
    assign out_frame_last = frame_last_reg;

`ifndef NO_ASSERTIONS
    a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csb_pkg::BACK_SECOND) |-> (!q_status.empty && head.has_second))
        else $error("second result without a queued request");
`endif

endmodule

// ----- rtl/cross_stencil_blur_unit.sv -----
// top level of the five-point cross average blur
//
// pixels enter on the s_axis channel in raster order, one 8-bit request per
// pixel; results leave on m_axis in raster order. frame size is set through
// the write port: index 0 row count, index 1 column count (up to 1024);
// writing either restarts the frame at row 0, col 0. write only while idle.
// border pixels are copied, interior pixels get (sum + 2) / 5 of the cross.
// the result for a pixel leaves once the pixel below it has arrived, so the
// first row gives nothing; each last-row request gives two results, the
// finished pixel above and its own copy. a one-row frame gives each pixel
// straight back. tlast marks the final pixel of the frame, tuser marks the
// final result of a request.
// results pass the front stage register, the queue and the output register,
// a last-row request's second result after its first. throughput: one
// request per cycle while the queue is not full, set by the single write
// port of each line store; on the last row the output register, giving two
// results per request, holds the input back. the front and back stall
// independently across a four-deep queue, so a stalled receiver only blocks
// s_axis once the queue and the front stage fill. reset clears position,
// queue and output valid, sets both counts to 1; line stores are not cleared
module cross_stencil_blur_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [csb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [csb_pkg::PIX_W-1:0]        s_axis_tdata,   // [7:0] pixel_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [csb_pkg::PIX_W-1:0]        m_axis_tdata,   // [7:0] pixel_out
    output logic                             m_axis_tuser,   // [0] run_last
    output logic                             m_axis_tlast    // frame_last
);

    csb_pkg::entry_t    q_entry;
    csb_pkg::entry_t    q_head;
    csb_pkg::q_status_t q_status;
    logic               q_push;
    logic               q_pop;

    // position tracking, line stores and stencil sum
    csb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pixel  (s_axis_tdata),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .q_status  (q_status)
    );

    // decouples the stencil from the output side
    csb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    // divide by five and split last-row requests into two results
    csb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .q_status       (q_status),
        .pop            (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_pixel      (m_axis_tdata),
        .out_run_last   (m_axis_tuser),
        .out_frame_last (m_axis_tlast)
    );

endmodule
